// ===== design/postfix_expression_evaluator_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator
// Implication checks on the rising clock edge, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PEE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("postfix evaluator: same-cycle check failed");

// Next-cycle implication.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("postfix evaluator: next-cycle check failed");

`endif

// ===== design/pee_pkg.sv =====
// ---------------------------------------------------------------------------
// pee_pkg
// Types, widths and character codes shared by the postfix evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [7:0]        char_t;
    typedef logic [1:0]        status_t;

    localparam char_t CH_ZERO    = 8'd48;
    localparam char_t CH_PLUS    = 8'd43;
    localparam char_t CH_MINUS   = 8'd45;
    localparam char_t CH_STAR    = 8'd42;
    localparam char_t CH_SLASH   = 8'd47;
    localparam char_t CH_PERCENT = 8'd37;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_UNDER   = 2'd1;
    localparam status_t ST_OVER    = 2'd2;
    localparam status_t ST_DIVZERO = 2'd3;

endpackage

`default_nettype wire

// ===== design/pee_in_if.sv =====
// ---------------------------------------------------------------------------
// pee_in_if
// Character channel: one expression character per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface pee_in_if;
    import pee_pkg::*;

    logic  valid;
    logic  ready;
    char_t symbol;
    logic  last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

// ===== design/pee_out_if.sv =====
// ---------------------------------------------------------------------------
// pee_out_if
// Result channel: one evaluated expression per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface pee_out_if;
    import pee_pkg::*;

    logic    valid;
    logic    ready;
    word_t   value;
    status_t status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== design/postfix_expression_evaluator_unit.sv =====
// ---------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Postfix (RPN) evaluator over a value stack, one character per beat.
// ---------------------------------------------------------------------------
// Characters arrive on the request channel, one per beat, the final one of
// an expression flagged by last. An operator byte (+ - * / %) pops the right
// operand, then the left, and pushes the 32-bit wrapped result; any other
// byte pushes its code minus 48. After the last character the stack top is
// popped and returned on the response channel with the first error of the
// expression (0 ok, 1 underflow, 2 overflow, 3 divide by zero); the stack
// and error are then cleared. One character is in flight at a time: the
// request is ready only while the sequencer is idle. A / or % runs 32
// restoring steps of the shared adder, unless the divisor is zero; a last
// character adds a final pop and hand-off. The stack is a single-port-read
// memory with registered read data, which sets the pop latency. A result
// waiting in the output register does not block the next expression until
// that expression is ready to emit. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "postfix_expression_evaluator_unit_defines.svh"

module postfix_expression_evaluator_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    pee_in_if.sink    request,
    pee_out_if.source response
);
    import pee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_R,
        S_POP_L,
        S_EXEC,
        S_ABS_N,
        S_ABS_D,
        S_DIV,
        S_FIX,
        S_PUSH,
        S_FINAL,
        S_EMIT
    } state_t;

    function automatic logic is_operator(input char_t c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_PERCENT);
    endfunction

    // control state
    state_t          state_reg;
    logic [SP_W-1:0] sp_reg;
    status_t         err_reg;
    logic            rd_hit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic            out_valid_reg;

    // datapath
    char_t   sym_reg;
    logic    last_reg;
    word_t   opb_reg;
    word_t   res_reg;
    word_t   quo_reg;
    word_t   rem_reg;
    word_t   den_reg;
    logic    nneg_reg;
    logic    dneg_reg;
    word_t   out_value_reg;
    status_t out_status_reg;

    // stack memory
    word_t   stack_mem [STACK_DEPTH];
    word_t   rd_data_reg;

    logic              accept;
    logic              pop_state;
    logic              stack_empty;
    logic              stack_full;
    logic [SP_W-1:0]   sp_dec;
    word_t             pop_data;
    logic              is_divrem;
    logic              emit_go;
    logic              div_bit;
    logic [WORD_W:0]   alu_a;
    logic [WORD_W:0]   alu_b;
    logic              alu_sub;
    logic [WORD_W+1:0] alu_sum;
    logic [2*WORD_W-1:0] mul_full;

    assign accept      = request.valid && request.ready;
    assign pop_state   = (state_reg == S_POP_R) || (state_reg == S_POP_L) ||
                         (state_reg == S_FINAL);
    assign stack_empty = (sp_reg == '0);
    assign stack_full  = (sp_reg >= SP_W'(STACK_DEPTH));
    assign sp_dec      = sp_reg - 1'b1;
    // an empty-stack pop reads as zero
    assign pop_data    = rd_hit_reg ? rd_data_reg : '0;
    assign is_divrem   = (sym_reg == CH_SLASH) || (sym_reg == CH_PERCENT);
    assign emit_go     = (state_reg == S_EMIT) && (!out_valid_reg || response.ready);

    assign request.ready   = (state_reg == S_IDLE);
    assign response.valid  = out_valid_reg;
    assign response.value  = out_value_reg;
    assign response.status = out_status_reg;

    // Shared adder: digit conversion, add, subtract, magnitudes, divide steps
    // and the final sign fix all go through here.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                alu_a   = (WORD_W+1)'(request.symbol);
                alu_b   = (WORD_W+1)'(CH_ZERO);
                alu_sub = 1'b1;
            end
            S_EXEC:
            begin
                alu_a   = {1'b0, pop_data};
                alu_b   = {1'b0, opb_reg};
                alu_sub = (sym_reg == CH_MINUS);
            end
            S_ABS_N:
            begin
                alu_b   = {1'b0, quo_reg};
                alu_sub = 1'b1;
            end
            S_ABS_D:
            begin
                alu_b   = {1'b0, den_reg};
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = {rem_reg, quo_reg[WORD_W-1]};
                alu_b   = {1'b0, den_reg};
                alu_sub = 1'b1;
            end
            S_FIX:
            begin
                if (sym_reg == CH_PERCENT)
                begin
                    alu_b   = {1'b0, rem_reg};
                    alu_sub = nneg_reg;
                end
                else
                begin
                    alu_b   = {1'b0, quo_reg};
                    alu_sub = nneg_reg ^ dneg_reg;
                end
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum  = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(WORD_W+2){alu_sub}}) +
                      (WORD_W+2)'(alu_sub);
    // trial subtract fits when the difference is not negative
    assign div_bit  = ~alu_sum[WORD_W+1];
    assign mul_full = {{WORD_W{1'b0}}, pop_data} * {{WORD_W{1'b0}}, opb_reg};

    // Sequencer: state, stack pointer, first error, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            rd_hit_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load a new result beat, or drop the one just taken
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= is_operator(request.symbol) ? S_POP_R : S_PUSH;
                    end
                end
                S_POP_R, S_POP_L, S_FINAL:
                begin
                    if (stack_empty)
                    begin
                        rd_hit_reg <= 1'b0;
                        if (err_reg == ST_OK)
                        begin
                            err_reg <= ST_UNDER;
                        end
                    end
                    else
                    begin
                        rd_hit_reg <= 1'b1;
                        sp_reg     <= sp_dec;
                    end
                    priority case (state_reg)
                        S_POP_R: state_reg <= S_POP_L;
                        S_POP_L: state_reg <= S_EXEC;
                        default: state_reg <= S_EMIT;
                    endcase
                end
                S_EXEC:
                begin
                    if (is_divrem && (opb_reg == '0))
                    begin
                        if (err_reg == ST_OK)
                        begin
                            err_reg <= ST_DIVZERO;
                        end
                        state_reg <= S_PUSH;
                    end
                    else if (is_divrem)
                    begin
                        state_reg <= S_ABS_N;
                    end
                    else
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_ABS_N:
                begin
                    state_reg <= S_ABS_D;
                end
                S_ABS_D:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WORD_W - 1))
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    // drop the value on a full stack
                    if (stack_full)
                    begin
                        if (err_reg == ST_OK)
                        begin
                            err_reg <= ST_OVER;
                        end
                    end
                    else
                    begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                    state_reg <= last_reg ? S_FINAL : S_IDLE;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        sp_reg        <= '0;
                        err_reg       <= ST_OK;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: operands, divider, result and output payload.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sym_reg  <= request.symbol;
                    last_reg <= request.last;
                    res_reg  <= alu_sum[WORD_W-1:0];
                end
            end
            S_POP_L:
            begin
                opb_reg <= pop_data;
            end
            S_EXEC:
            begin
                if (sym_reg == CH_STAR)
                begin
                    res_reg <= mul_full[WORD_W-1:0];
                end
                else if (is_divrem)
                begin
                    res_reg  <= '0;
                    quo_reg  <= pop_data;
                    den_reg  <= opb_reg;
                    nneg_reg <= pop_data[WORD_W-1];
                    dneg_reg <= opb_reg[WORD_W-1];
                    rem_reg  <= '0;
                end
                else
                begin
                    res_reg <= alu_sum[WORD_W-1:0];
                end
            end
            S_ABS_N:
            begin
                if (nneg_reg)
                begin
                    quo_reg <= alu_sum[WORD_W-1:0];
                end
            end
            S_ABS_D:
            begin
                if (dneg_reg)
                begin
                    den_reg <= alu_sum[WORD_W-1:0];
                end
            end
            S_DIV:
            begin
                rem_reg <= div_bit ? alu_sum[WORD_W-1:0]
                                   : {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
                quo_reg <= {quo_reg[WORD_W-2:0], div_bit};
            end
            S_FIX:
            begin
                res_reg <= alu_sum[WORD_W-1:0];
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_value_reg  <= pop_data;
                    out_status_reg <= err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Stack memory: push writes, pops read with registered data.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PUSH) && !stack_full)
        begin
            stack_mem[sp_reg[ADDR_W-1:0]] <= res_reg;
        end
        if (pop_state && !stack_empty)
        begin
            rd_data_reg <= stack_mem[sp_dec[ADDR_W-1:0]];
        end
    end

    `PEE_ASSERT_IMPL(a_sp_in_range, clk, rst_n, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `PEE_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_go,
        (sp_reg == '0) && (err_reg == ST_OK) && out_valid_reg)
    `PEE_ASSERT_NEXT(a_divzero_noted, clk, rst_n,
        (state_reg == S_EXEC) && is_divrem && (opb_reg == '0) && (err_reg == ST_OK),
        err_reg == ST_DIVZERO)

endmodule

`default_nettype wire
